/* hdl/abf_pkg.sv */
// Shared types, widths and helpers for the angle bisector foot pipeline.
// No dependencies; every other file imports this package.
package abf_pkg;

  localparam int COORD_W   = 32;
  localparam int LEN_GUARD = 8;
  localparam int MAG_W     = COORD_W + 1;
  localparam int LEN_W     = MAG_W + LEN_GUARD;
  localparam int RAD_W     = 2 * LEN_W;
  localparam int DEN_W     = LEN_W + 1;
  localparam int PROD_W    = MAG_W + LEN_W;
  localparam int NUM_W     = PROD_W + 2;
  localparam int DIV_W     = DEN_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] apex_x;
    logic signed [COORD_W-1:0] apex_y;
    logic signed [COORD_W-1:0] p_x;
    logic signed [COORD_W-1:0] p_y;
    logic signed [COORD_W-1:0] q_x;
    logic signed [COORD_W-1:0] q_y;
  } tri_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] foot_x;
    logic signed [COORD_W-1:0] foot_y;
    logic                      degenerate;
  } foot_t;

  // Control and pass-through data that travel alongside the arithmetic.
  typedef struct packed {
    logic                      valid;
    logic                      degen;
    logic signed [COORD_W-1:0] p_x;
    logic signed [COORD_W-1:0] p_y;
    logic [MAG_W-1:0]          dmag_x;
    logic [MAG_W-1:0]          dmag_y;
    logic                      dneg_x;
    logic                      dneg_y;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [MAG_W-1:0] d);
    abs_mag = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

endpackage

/* hdl/abf_mul.sv */
// Two-stage unsigned multiplier built from four registered partial products.
// Depends on abf_pkg for default widths.
module abf_mul
  import abf_pkg::*;
#(
  parameter int A_W = MAG_W,
  parameter int B_W = MAG_W
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0] p
);

  localparam int AL  = A_W / 2;
  localparam int AH  = A_W - AL;
  localparam int BL  = B_W / 2;
  localparam int BH  = B_W - BL;
  localparam int P_W = A_W + B_W;

  logic [AL+BL-1:0] ll_r;
  logic [AL+BH-1:0] lh_r;
  logic [AH+BL-1:0] hl_r;
  logic [AH+BH-1:0] hh_r;
  logic [P_W-1:0]   p_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ll_r <= a[AL-1:0] * b[BL-1:0];
      lh_r <= a[AL-1:0] * b[B_W-1:BL];
      hl_r <= a[A_W-1:AL] * b[BL-1:0];
      hh_r <= a[A_W-1:AL] * b[B_W-1:BL];
      p_r  <= (P_W'(hh_r) << (AL + BL)) + (P_W'(hl_r) << AL) +
              (P_W'(lh_r) << BL) + P_W'(ll_r);
    end
  end

  assign p = p_r;

endmodule

/* hdl/abf_sqrt.sv */
// Two-lane pipelined integer square root, one result bit per stage.
// Depends on abf_pkg for default widths; carries a side word with each item.
module abf_sqrt
  import abf_pkg::*;
#(
  parameter int ROOT_W = LEN_W,
  parameter int SW     = SIDE_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [2*ROOT_W-1:0] rad_i [2],
  input  logic [SW-1:0]       side_i,
  output logic [ROOT_W-1:0]   root_o [2],
  output logic [SW-1:0]       side_o
);

  localparam int RW  = 2 * ROOT_W;
  localparam int REM = ROOT_W + 3;

  logic [RW-1:0]     rad_r  [2][1:ROOT_W-1];
  logic [REM-1:0]    rem_r  [2][1:ROOT_W-1];
  logic [ROOT_W-1:0] root_r [2][1:ROOT_W];
  logic [SW-1:0]     side_r [1:ROOT_W];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [RW-1:0]     rad_c;
      logic [REM-1:0]    rem_c, rem_sh, trial;
      logic [ROOT_W-1:0] root_c;
      logic              ge;

      if (k == 0) begin : g_first
        assign rad_c  = rad_i[l];
        assign rem_c  = '0;
        assign root_c = '0;
      end else begin : g_next
        assign rad_c  = rad_r[l][k];
        assign rem_c  = rem_r[l][k];
        assign root_c = root_r[l][k];
      end

      // Bring down the next two radicand bits and try a one in the root.
      assign rem_sh = {rem_c[REM-3:0], rad_c[RW-1:RW-2]};
      assign trial  = REM'({root_c, 2'b01});
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (adv) begin
          root_r[l][k+1] <= {root_c[ROOT_W-2:0], ge};
        end
      end

      if (k + 1 < ROOT_W) begin : g_keep
        always_ff @(posedge clk) begin
          if (adv) begin
            rad_r[l][k+1] <= {rad_c[RW-3:0], 2'b00};
            rem_r[l][k+1] <= ge ? rem_sh - trial : rem_sh;
          end
        end
      end
    end
    assign root_o[l] = root_r[l][ROOT_W];
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k+1] <= '0;
      end else if (adv) begin
        side_r[k+1] <= (k == 0) ? side_i : side_r[(k == 0) ? 1 : k];
      end
    end
  end

  assign side_o = side_r[ROOT_W];

endmodule

/* hdl/abf_div.sv */
// Two-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage. Depends on abf_pkg for default widths.
module abf_div
  import abf_pkg::*;
#(
  parameter int Q_W  = MAG_W,
  parameter int D_W  = DIV_W,
  parameter int SW   = SIDE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [Q_W+D_W-1:0] num_i [2],
  input  logic [D_W-1:0]     div_i,
  input  logic [SW-1:0]      side_i,
  output logic [Q_W-1:0]     quo_o [2],
  output logic [SW-1:0]      side_o
);

  logic [D_W-1:0] rem_r [2][1:Q_W-1];
  logic [Q_W-1:0] lo_r  [2][1:Q_W-1];
  logic [Q_W-1:0] quo_r [2][1:Q_W];
  logic [D_W-1:0] div_r [1:Q_W-1];
  logic [SW-1:0]  side_r [1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [D_W-1:0] div_c;
    if (k == 0) begin : g_first
      assign div_c = div_i;
    end else begin : g_next
      assign div_c = div_r[k];
    end
    if (k + 1 < Q_W) begin : g_keep_div
      always_ff @(posedge clk) begin
        if (adv) begin
          div_r[k+1] <= div_c;
        end
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [D_W-1:0] rem_c;
      logic [Q_W-1:0] lo_c, quo_c;
      logic [D_W:0]   rem_sh, rem_sub;
      logic           ge;

      if (k == 0) begin : g_first
        // The quotient fits Q_W bits, so the top part starts below the divisor.
        assign rem_c = num_i[l][Q_W+D_W-1:Q_W];
        assign lo_c  = num_i[l][Q_W-1:0];
        assign quo_c = '0;
      end else begin : g_next
        assign rem_c = rem_r[l][k];
        assign lo_c  = lo_r[l][k];
        assign quo_c = quo_r[l][k];
      end

      assign rem_sh  = {rem_c, lo_c[Q_W-1]};
      assign ge      = rem_sh >= {1'b0, div_c};
      assign rem_sub = rem_sh - {1'b0, div_c};

      always_ff @(posedge clk) begin
        if (adv) begin
          quo_r[l][k+1] <= {quo_c[Q_W-2:0], ge};
        end
      end

      if (k + 1 < Q_W) begin : g_keep
        always_ff @(posedge clk) begin
          if (adv) begin
            rem_r[l][k+1] <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
            lo_r[l][k+1]  <= {lo_c[Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k+1] <= '0;
      end else if (adv) begin
        side_r[k+1] <= (k == 0) ? side_i : side_r[(k == 0) ? 1 : k];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_out
    assign quo_o[l] = quo_r[l][Q_W];
  end
  assign side_o = side_r[Q_W];

endmodule

/* hdl/angle_bisector_foot.sv */
// Top level of the angle bisector foot pipeline.
// Depends on abf_pkg, abf_mul, abf_sqrt and abf_div.
//
//  channel | ports                       | payload
//  --------+-----------------------------+---------
//  input   | in_valid, in_ready, in_data | tri_t
//  result  | out_valid, out_ready, out_data | foot_t
//
// One triangle is accepted per cycle while the output is not stalled.
// Most of the pipeline depth lies in the square root and divider stages, one bit each.
// The whole pipeline advances together whenever the output register is
// empty or being taken; a stalled output holds every stage in place.
// Reset clears the valid bits of all stages.
module angle_bisector_foot
  import abf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  tri_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output foot_t out_data
);

  logic adv;
  logic out_valid_r;
  foot_t out_data_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage A: differences and magnitudes.
  logic signed [MAG_W-1:0] ux, uy, vx, vy, dx, dy;
  side_t a_side_nxt, a_side_r;
  logic [MAG_W-1:0] a_mag_r [4];
  logic [1:0] a_n_r;

  assign ux = MAG_W'(in_data.p_x) - MAG_W'(in_data.apex_x);
  assign uy = MAG_W'(in_data.p_y) - MAG_W'(in_data.apex_y);
  assign vx = MAG_W'(in_data.q_x) - MAG_W'(in_data.apex_x);
  assign vy = MAG_W'(in_data.q_y) - MAG_W'(in_data.apex_y);
  assign dx = MAG_W'(in_data.q_x) - MAG_W'(in_data.p_x);
  assign dy = MAG_W'(in_data.q_y) - MAG_W'(in_data.p_y);

  always_comb begin
    a_side_nxt        = '0;
    a_side_nxt.valid  = in_valid;
    a_side_nxt.p_x    = in_data.p_x;
    a_side_nxt.p_y    = in_data.p_y;
    a_side_nxt.dmag_x = abs_mag(dx);
    a_side_nxt.dmag_y = abs_mag(dy);
    a_side_nxt.dneg_x = dx[MAG_W-1];
    a_side_nxt.dneg_y = dy[MAG_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_side_r <= '0;
    end else if (adv) begin
      a_side_r <= a_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mag_r[0] <= abs_mag(ux);
      a_mag_r[1] <= abs_mag(uy);
      a_mag_r[2] <= abs_mag(vx);
      a_mag_r[3] <= abs_mag(vy);
      a_n_r      <= {uy[MAG_W-1] != vx[MAG_W-1], ux[MAG_W-1] != vy[MAG_W-1]};
    end
  end

  // Stage B: cross-product terms and squared lengths.
  logic [2*MAG_W-1:0] m1, m2, sq_ux, sq_uy, sq_vx, sq_vy;

  abf_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_m1 (.clk, .adv, .a(a_mag_r[0]), .b(a_mag_r[3]), .p(m1));
  abf_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_m2 (.clk, .adv, .a(a_mag_r[1]), .b(a_mag_r[2]), .p(m2));
  abf_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_s0 (.clk, .adv, .a(a_mag_r[0]), .b(a_mag_r[0]), .p(sq_ux));
  abf_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_s1 (.clk, .adv, .a(a_mag_r[1]), .b(a_mag_r[1]), .p(sq_uy));
  abf_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_s2 (.clk, .adv, .a(a_mag_r[2]), .b(a_mag_r[2]), .p(sq_vx));
  abf_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_s3 (.clk, .adv, .a(a_mag_r[3]), .b(a_mag_r[3]), .p(sq_vy));

  side_t b1_side_r, b2_side_r;
  logic [1:0] b1_n_r, b2_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_side_r <= '0;
      b2_side_r <= '0;
    end else if (adv) begin
      b1_side_r <= a_side_r;
      b2_side_r <= b1_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_n_r <= a_n_r;
      b2_n_r <= b1_n_r;
    end
  end

  // Stage C: the triangle is degenerate when the cross product is zero.
  logic z1, z2, collinear;
  side_t c_side_nxt, c_side_r;
  logic [RAD_W-1:0] c_rad_r [2];

  assign z1 = m1 == '0;
  assign z2 = m2 == '0;
  assign collinear = (z1 && z2) || (!z1 && !z2 && (b2_n_r[0] == b2_n_r[1]) && (m1 == m2));

  always_comb begin
    c_side_nxt       = b2_side_r;
    c_side_nxt.degen = collinear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_side_r <= '0;
    end else if (adv) begin
      c_side_r <= c_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_rad_r[0] <= {sq_ux + sq_uy, (2 * LEN_GUARD)'(0)};
      c_rad_r[1] <= {sq_vx + sq_vy, (2 * LEN_GUARD)'(0)};
    end
  end

  // Stage D: both side lengths.
  logic [LEN_W-1:0] len [2];
  logic [SIDE_W-1:0] d_side;

  abf_sqrt #(.ROOT_W(LEN_W), .SW(SIDE_W)) u_sqrt (
    .clk, .rst_n, .adv,
    .rad_i(c_rad_r), .side_i(c_side_r),
    .root_o(len), .side_o(d_side)
  );

  // Stage E: length sum.
  side_t e_side_r;
  logic [LEN_W-1:0] e_lp_r;
  logic [DEN_W-1:0] e_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_side_r <= '0;
    end else if (adv) begin
      e_side_r <= side_t'(d_side);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_lp_r  <= len[0];
      e_den_r <= DEN_W'(len[0]) + DEN_W'(len[1]);
    end
  end

  // Stage F: scale each side extent by |AP|.
  logic [PROD_W-1:0] prod_x, prod_y;

  abf_mul #(.A_W(MAG_W), .B_W(LEN_W)) u_px (
    .clk, .adv, .a(e_side_r.dmag_x), .b(e_lp_r), .p(prod_x));
  abf_mul #(.A_W(MAG_W), .B_W(LEN_W)) u_py (
    .clk, .adv, .a(e_side_r.dmag_y), .b(e_lp_r), .p(prod_y));

  side_t f1_side_r, f2_side_r;
  logic [DEN_W-1:0] f1_den_r, f2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_side_r <= '0;
      f2_side_r <= '0;
    end else if (adv) begin
      f1_side_r <= e_side_r;
      f2_side_r <= f1_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_den_r <= e_den_r;
      f2_den_r <= f1_den_r;
    end
  end

  // Stage G: rounded quotient operands, (2*n + D) / (2*D).
  side_t g_side_nxt, g_side_r;
  logic [NUM_W-1:0] g_num_r [2];
  logic [DIV_W-1:0] g_div_r;

  always_comb begin
    g_side_nxt       = f2_side_r;
    g_side_nxt.degen = f2_side_r.degen || (f2_den_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_side_r <= '0;
    end else if (adv) begin
      g_side_r <= g_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_num_r[0] <= {prod_x, 1'b0} + NUM_W'(f2_den_r);
      g_num_r[1] <= {prod_y, 1'b0} + NUM_W'(f2_den_r);
      g_div_r    <= {f2_den_r, 1'b0};
    end
  end

  // Stage H: division.
  logic [MAG_W-1:0] quo [2];
  logic [SIDE_W-1:0] h_side_w;
  side_t h_side;

  abf_div #(.Q_W(MAG_W), .D_W(DIV_W), .SW(SIDE_W)) u_div (
    .clk, .rst_n, .adv,
    .num_i(g_num_r), .div_i(g_div_r), .side_i(g_side_r),
    .quo_o(quo), .side_o(h_side_w)
  );

  assign h_side = side_t'(h_side_w);

  // Output register: the foot moves from P towards Q by the quotient.
  logic signed [COORD_W+1:0] foot_x_w, foot_y_w;
  foot_t out_data_nxt;

  assign foot_x_w = h_side.dneg_x ? (COORD_W+2)'(h_side.p_x) - $signed({1'b0, quo[0]})
                                  : (COORD_W+2)'(h_side.p_x) + $signed({1'b0, quo[0]});
  assign foot_y_w = h_side.dneg_y ? (COORD_W+2)'(h_side.p_y) - $signed({1'b0, quo[1]})
                                  : (COORD_W+2)'(h_side.p_y) + $signed({1'b0, quo[1]});

  always_comb begin
    out_data_nxt            = '0;
    out_data_nxt.degenerate = h_side.degen;
    if (!h_side.degen) begin
      out_data_nxt.foot_x = foot_x_w[COORD_W-1:0];
      out_data_nxt.foot_y = foot_y_w[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= h_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/abf_checker.sv */
// Port-level checks for angle_bisector_foot, attached by the bind below.
// Depends on abf_pkg for the payload types.
module abf_checker
  import abf_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input foot_t out_data
);

  // A result waiting to be taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before it was taken");

  // A degenerate triangle always reports a zero foot.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.foot_x == '0 && out_data.foot_y == '0)
    else $error("degenerate result carries a non-zero foot");

  // A stalled result freezes the whole pipeline, so no request can enter.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the pipeline is stalled");

  // With no result waiting, the pipeline always takes a request.
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with an empty output register");

  // The first cycle after reset shows no result.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind angle_bisector_foot abf_checker u_abf_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_data
);
